/* hdl/xed_pkg.sv */
`default_nettype none

package xed_pkg;

	localparam logic [7:0] AMP_CHAR  = 8'h26;
	localparam logic [7:0] SEMI_CHAR = 8'h3B;
	localparam logic [2:0] NAME_MAX  = 3'd4;
	localparam int         NUM_ENT   = 7;
	localparam int         JOB_BYTES = 6;
	localparam int         FIFO_DEPTH = 4;

	// decoder mode, one-hot
	typedef enum logic [2:0] {
		MODE_NORMAL  = 3'b001,
		MODE_COLLECT = 3'b010,
		MODE_PASS    = 3'b100
	} mode_t;

	typedef struct packed {
		logic [7:0] in_char;
		logic       string_last;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       run_last;
		logic       string_end;
	} out_item_t;

	// one queued job: the result bytes of one input item
	typedef struct packed {
		logic [JOB_BYTES-1:0][7:0] bytes;
		logic [2:0]                len;
		logic                      str_last;
	} job_t;

	typedef struct packed {
		logic hit;
		logic [7:0] value;
	} ent_hit_t;

	localparam logic [2:0] ENT_LEN [NUM_ENT] = '{3'd3, 3'd2, 3'd2, 3'd4, 3'd4, 3'd4, 3'd3};
	localparam logic [7:0] ENT_TXT [NUM_ENT][4] = '{
		'{"a", "m", "p", 8'h00},
		'{"l", "t", 8'h00, 8'h00},
		'{"g", "t", 8'h00, 8'h00},
		'{"q", "u", "o", "t"},
		'{"a", "p", "o", "s"},
		'{"c", "o", "p", "y"},
		'{"r", "e", "g", 8'h00}
	};
	localparam logic [7:0] ENT_VAL [NUM_ENT] = '{8'h26, 8'h3C, 8'h3E, 8'h22, 8'h27, 8'hA9, 8'hAE};

	// name of cnt bytes against the entity table; only bytes below cnt are compared
	function automatic ent_hit_t entity_lookup(logic [3:0][7:0] name, logic [2:0] cnt);
		ent_hit_t r;
		logic     ok;
		r = '0;
		for (int k = 0; k < NUM_ENT; k++) begin
			ok = (ENT_LEN[k] == cnt);
			for (int j = 0; j < 4; j++) begin
				if ((3'(j) < cnt) && (name[j] != ENT_TXT[k][j]))
					ok = 1'b0;
			end
			if (ok) begin
				r.hit   = 1'b1;
				r.value = ENT_VAL[k];
			end
		end
		return r;
	endfunction

endpackage

`default_nettype wire

/* hdl/xed_front.sv */
`default_nettype none

module xed_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire xed_pkg::in_item_t text_byte,
	input  wire logic              q_full,
	output logic                   q_wr,
	output xed_pkg::job_t          q_job
);
	import xed_pkg::*;

	mode_t           mode_q, mode_d;
	logic [2:0]      cnt_q, cnt_d;
	logic [3:0][7:0] buf_q, nb;
	logic            buf_we;
	logic            single;
	logic [7:0]      sval, tail, c;
	logic [2:0]      k;
	logic [2:0]      len;
	logic            accept;
	ent_hit_t        ent;

	assign c      = text_byte.in_char;
	assign accept = push && !q_full;
	assign ent    = entity_lookup(buf_q, cnt_q);

	always_comb begin
		mode_d = mode_q;
		cnt_d  = cnt_q;
		nb     = buf_q;
		buf_we = 1'b0;
		single = 1'b0;
		sval   = c;
		tail   = c;
		k      = 3'd0;
		len    = 3'd0;
		case (mode_q)
			MODE_COLLECT: begin
				if (c == SEMI_CHAR) begin
					if (ent.hit) begin
						single = 1'b1;
						sval   = ent.value;
						len    = 3'd1;
					end else begin
						k    = cnt_q;
						tail = SEMI_CHAR;
						len  = 3'(cnt_q + 3'd2);
					end
					mode_d = MODE_NORMAL;
					cnt_d  = 3'd0;
				end else if (cnt_q < NAME_MAX) begin
					nb[cnt_q[1:0]] = c;
					buf_we = 1'b1;
					cnt_d  = 3'(cnt_q + 3'd1);
					if (text_byte.string_last) begin
						// unterminated name: '&' plus buffered bytes
						k   = 3'(cnt_q + 3'd1);
						len = 3'(cnt_q + 3'd2);
					end
				end else begin
					// name too long: flush and pass through until ';'
					k      = NAME_MAX;
					len    = 3'(JOB_BYTES);
					mode_d = MODE_PASS;
					cnt_d  = 3'd0;
				end
			end
			MODE_PASS: begin
				single = 1'b1;
				len    = 3'd1;
				if (c == SEMI_CHAR)
					mode_d = MODE_NORMAL;
			end
			default: begin
				if (c == AMP_CHAR) begin
					mode_d = MODE_COLLECT;
					cnt_d  = 3'd0;
					if (text_byte.string_last)
						len = 3'd1;
				end else begin
					single = 1'b1;
					len    = 3'd1;
				end
			end
		endcase
		if (text_byte.string_last) begin
			mode_d = MODE_NORMAL;
			cnt_d  = 3'd0;
		end
	end

	// job bytes: a single byte, or '&', k name bytes, then the tail byte
	always_comb begin
		q_job          = '0;
		q_job.bytes[0] = single ? sval : AMP_CHAR;
		for (int i = 1; i < JOB_BYTES - 1; i++)
			q_job.bytes[i] = (3'(i - 1) < k) ? nb[i-1] : tail;
		q_job.bytes[JOB_BYTES-1] = tail;
		q_job.len      = len;
		q_job.str_last = text_byte.string_last;
	end

	assign q_wr = accept && (len != 3'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_NORMAL;
			cnt_q  <= 3'd0;
		end else if (accept) begin
			mode_q <= mode_d;
			cnt_q  <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && buf_we)
			buf_q <= nb;
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= NAME_MAX) else $error("name count out of range");
	a_cnt_mode: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q != MODE_COLLECT |-> cnt_q == 3'd0) else $error("stale name count");

endmodule

`default_nettype wire

/* hdl/xed_fifo.sv */
`default_nettype none

module xed_fifo (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          wr_en,
	input  wire xed_pkg::job_t wr_job,
	output logic               full,
	input  wire logic          rd_en,
	output xed_pkg::job_t      head,
	output logic               head_valid
);
	import xed_pkg::*;

	localparam int PW = $clog2(FIFO_DEPTH);

	job_t          mem_q [FIFO_DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [PW:0]   cnt_q;

	assign full       = (cnt_q == (PW+1)'(FIFO_DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en)
				wr_ptr_q <= PW'(wr_ptr_q + 1'b1);
			if (rd_en)
				rd_ptr_q <= PW'(rd_ptr_q + 1'b1);
			if (wr_en && !rd_en)
				cnt_q <= (PW+1)'(cnt_q + 1'b1);
			else if (rd_en && !wr_en)
				cnt_q <= (PW+1)'(cnt_q - 1'b1);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_ptr_q] <= wr_job;
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> !full) else $error("job queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> head_valid) else $error("job queue underflow");
	a_job_len: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (wr_job.len != 3'd0) && (wr_job.len <= 3'(JOB_BYTES)))
		else $error("bad job length");

endmodule

`default_nettype wire

/* hdl/xed_back.sv */
`default_nettype none

module xed_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire xed_pkg::job_t head,
	input  wire logic          head_valid,
	output logic               q_rd,
	output xed_pkg::out_item_t dec_byte,
	output logic               empty,
	input  wire logic          pop
);
	import xed_pkg::*;

	logic [2:0] idx_q;
	logic       out_valid_q;
	out_item_t  out_q;
	logic       load, is_last, taken;

	assign taken   = pop && out_valid_q;
	assign load    = head_valid && (!out_valid_q || taken);
	assign is_last = (idx_q == 3'(head.len - 3'd1));
	assign q_rd    = load && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= 3'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (load)
				idx_q <= is_last ? 3'd0 : 3'(idx_q + 3'd1);
			if (load)
				out_valid_q <= 1'b1;
			else if (taken)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q.out_char   <= head.bytes[idx_q];
			out_q.run_last   <= is_last;
			out_q.string_end <= is_last && head.str_last;
		end
	end

	assign dec_byte = out_q;
	assign empty    = !out_valid_q;

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> idx_q < head.len) else $error("byte index past job end");

endmodule

`default_nettype wire

/* hdl/xml_entity_decoder.sv */
// A result goes through the job queue, then the output register. Throughput: one
// item per cycle while not full; one result byte per cycle while pop takes it, so the
// rare flushes of up to six bytes hold the input off through the four-deep job queue.
// Reset (arst_n, asynchronous, active low): normal mode, name count zero,
// job queue and output register empty.
`default_nettype none

module xml_entity_decoder (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	output logic                    full,
	input  wire xed_pkg::in_item_t  text_byte,
	output logic                    empty,
	input  wire logic               pop,
	output xed_pkg::out_item_t      dec_byte
);
	import xed_pkg::*;

	// front -> queue
	logic q_wr;
	job_t q_job;
	// queue -> back
	job_t head;
	logic head_valid;
	logic q_rd;

	// Front: tracks the decode mode and the name bytes after '&', looks
	// up the entity on ';' and turns each item into one job holding all
	// of its result bytes. Items that yield nothing push no job.
	xed_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.text_byte (text_byte),
		.q_full    (full),
		.q_wr      (q_wr),
		.q_job     (q_job)
	);

	// Job queue: decouples classification from byte-wise emission.
	// Its full flag is the input backpressure.
	xed_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (q_wr),
		.wr_job     (q_job),
		.full       (full),
		.rd_en      (q_rd),
		.head       (head),
		.head_valid (head_valid)
	);

	// Back: walks the head job into the output register, one byte per cycle while
	// it is free or popped, marking the last byte of the job and of the string.
	xed_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.q_rd       (q_rd),
		.dec_byte   (dec_byte),
		.empty      (empty),
		.pop        (pop)
	);

endmodule

`default_nettype wire
